[src/assert_macros.svh]
// Assertion macros shared by the range assign tree RTL.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RAST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");
`define RAST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define RAST_ASSERT(lbl, prop)
`define RAST_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

[src/rast_pkg.sv]
// Shared constants, node type and node arithmetic for the range assign tree.
// No dependencies.
package rast_pkg;
    localparam int LEAVES     = 1024;
    localparam int LVLS       = 10;
    localparam int NODES      = 2 * LEAVES;
    localparam int NIDX_W     = 11;
    localparam int LVL_W      = 4;
    localparam int VALUE_BITS = 32;
    localparam int SUM_W      = 44;
    localparam int OUT_W      = 41;
    localparam int CNT_W      = 11;

    typedef struct packed {
        logic signed [SUM_W-1:0]      best;
        logic signed [SUM_W-1:0]      prefix;
        logic signed [SUM_W-1:0]      suffix;
        logic signed [SUM_W-1:0]      total;
        logic signed [VALUE_BITS-1:0] pval;
        logic                         pon;
    } t_node;

    function automatic logic signed [SUM_W-1:0] max2(input logic signed [SUM_W-1:0] a,
                                                     input logic signed [SUM_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_node set_node(input logic signed [VALUE_BITS-1:0] v,
                                       input logic [LVL_W-1:0] k);
        t_node n;
        logic signed [SUM_W-1:0] t;
        logic signed [SUM_W-1:0] p;
        t = $signed({{(SUM_W-VALUE_BITS){v[VALUE_BITS-1]}}, v}) <<< k;
        p = t[SUM_W-1] ? '0 : t;
        n.best   = p;
        n.prefix = p;
        n.suffix = p;
        n.total  = t;
        n.pval   = v;
        n.pon    = 1'b1;
        return n;
    endfunction

    function automatic t_node pull_up(input t_node a, input t_node b);
        t_node n;
        n.best   = max2(max2(a.best, b.best), a.suffix + b.prefix);
        n.prefix = max2(a.prefix, a.total + b.prefix);
        n.suffix = max2(b.suffix, b.total + a.suffix);
        n.total  = a.total + b.total;
        n.pval   = '0;
        n.pon    = 1'b0;
        return n;
    endfunction
endpackage

[src/rast_node_mem.sv]
// Node memory of the tree: one write port, one registered read port.
// Depends on rast_pkg.
module rast_node_mem import rast_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [NIDX_W-1:0] i_waddr,
    input  t_node             i_wdata,
    input  logic [NIDX_W-1:0] i_raddr,
    output t_node             o_rdata
);
    t_node r_mem [NODES];
    t_node r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/range_assign_max_subarray_tree_top.sv]
// An empty range answers in the cycle after it is taken; an update walks the visited nodes
// one after another through the single node memory port pair.
// Throughput: one item at a time; a new item is taken once the previous result is gone.
// Reset and every leaf_count write start a clearing pass over every node, one node a
// cycle, during which no item is accepted. Reset is synchronous, active low.
// Top level of the range assign tree; depends on rast_pkg, rast_node_mem, assert_macros.svh.
`include "assert_macros.svh"
module range_assign_max_subarray_tree_top import rast_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [9:0]                   i_range_left,
    input  logic [10:0]                  i_range_right,
    input  logic signed [VALUE_BITS-1:0] i_assign_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [OUT_W-1:0]             o_best_run_sum,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RD, S_EV, S_PD2, S_RET, S_PU1, S_PU3
    } t_state;

    t_state                  r_state;
    logic                    r_pu2;
    logic [NIDX_W-1:0]       r_x;
    logic [LVL_W-1:0]        r_lvl;
    logic [9:0]              r_l;
    logic [CNT_W-1:0]        r_r;
    logic signed [VALUE_BITS-1:0] r_v;
    logic signed [VALUE_BITS-1:0] r_pval;
    t_node                   r_left;
    logic signed [SUM_W-1:0] r_root_best;
    logic [CNT_W-1:0]        r_leaf_count;
    logic [NIDX_W-1:0]       r_clr_cnt;
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_sum;

    logic              we;
    logic [NIDX_W-1:0] waddr;
    logic [NIDX_W-1:0] raddr;
    t_node             wdata;
    t_node             rdata;
    logic [NIDX_W-1:0] w_lo;
    logic [NIDX_W-1:0] w_hi;
    logic [LVL_W-1:0]  w_k;
    logic              w_disj;
    logic              w_cont;
    logic [CNT_W-1:0]  w_cnt;
    logic [CNT_W-1:0]  w_rr;
    logic              w_cfg_wr;
    logic [OUT_W-1:0]  w_root_out;

    rast_node_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign pready   = 1'b1;
    assign prdata   = {{(32-CNT_W){1'b0}}, r_leaf_count};
    assign w_cfg_wr = psel && penable && pwrite && !paddr[2];

    assign w_k    = LVL_W'(LVLS) - r_lvl;
    assign w_lo   = NIDX_W'((r_x & ~(NIDX_W'(1) << r_lvl)) << w_k);
    assign w_hi   = w_lo + (NIDX_W'(1) << w_k);
    assign w_disj = (w_lo >= r_r) || (w_hi <= {1'b0, r_l});
    assign w_cont = ({1'b0, r_l} <= w_lo) && (w_hi <= r_r);

    assign w_cnt = (r_leaf_count > CNT_W'(LEAVES)) ? CNT_W'(LEAVES) : r_leaf_count;
    assign w_rr  = (i_range_right > w_cnt) ? w_cnt : i_range_right;
    assign w_root_out = r_root_best[SUM_W-1] ? '0 : r_root_best[OUT_W-1:0];

    assign o_in_stall     = !(r_state == S_IDLE && !r_out_valid);
    assign o_out_valid    = r_out_valid;
    assign o_best_run_sum = r_out_sum;

    always_comb begin
        we    = 1'b0;
        waddr = r_x;
        wdata = '0;
        raddr = r_x;
        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr_cnt;
            end
            S_EV: begin
                if (!w_disj && w_cont) begin
                    we    = 1'b1;
                    wdata = set_node(r_v, w_k);
                end else if (!w_disj && rdata.pon) begin
                    we    = 1'b1;
                    waddr = {r_x[NIDX_W-2:0], 1'b0};
                    wdata = set_node(rdata.pval, w_k - LVL_W'(1));
                end
            end
            S_PD2: begin
                we    = 1'b1;
                waddr = {r_x[NIDX_W-2:0], 1'b1};
                wdata = set_node(r_pval, w_k - LVL_W'(1));
            end
            S_PU1: begin
                raddr = r_pu2 ? {r_x[NIDX_W-2:0], 1'b1} : {r_x[NIDX_W-2:0], 1'b0};
            end
            S_PU3: begin
                we    = 1'b1;
                wdata = pull_up(r_left, rdata);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_cnt    <= '0;
            r_leaf_count <= CNT_W'(LEAVES);
            r_out_valid  <= 1'b0;
            r_root_best  <= '0;
            r_pu2        <= 1'b0;
            r_x          <= NIDX_W'(1);
            r_lvl        <= '0;
        end else begin
            if (we && waddr == NIDX_W'(1)) begin
                r_root_best <= wdata.best;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_wr) begin
                r_leaf_count <= pwdata[CNT_W-1:0];
                r_clr_cnt    <= '0;
                r_state      <= S_CLEAR;
            end else begin
                unique case (r_state)
                    S_CLEAR: begin
                        r_clr_cnt <= r_clr_cnt + NIDX_W'(1);
                        if (r_clr_cnt == NIDX_W'(NODES - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (i_in_valid && !o_in_stall) begin
                            r_l <= i_range_left;
                            r_r <= w_rr;
                            r_v <= i_assign_value;
                            if ({1'b0, i_range_left} < w_rr) begin
                                r_x     <= NIDX_W'(1);
                                r_lvl   <= '0;
                                r_state <= S_RD;
                            end else begin
                                r_out_valid <= 1'b1;
                                r_out_sum   <= w_root_out;
                            end
                        end
                    end
                    S_RD: begin
                        r_state <= S_EV;
                    end
                    S_EV: begin
                        if (w_disj || w_cont) begin
                            r_state <= S_RET;
                        end else if (rdata.pon) begin
                            r_pval  <= rdata.pval;
                            r_state <= S_PD2;
                        end else begin
                            r_x     <= {r_x[NIDX_W-2:0], 1'b0};
                            r_lvl   <= r_lvl + LVL_W'(1);
                            r_state <= S_RD;
                        end
                    end
                    S_PD2: begin
                        r_x     <= {r_x[NIDX_W-2:0], 1'b0};
                        r_lvl   <= r_lvl + LVL_W'(1);
                        r_state <= S_RD;
                    end
                    S_RET: begin
                        if (r_lvl == '0) begin
                            r_out_valid <= 1'b1;
                            r_out_sum   <= w_root_out;
                            r_state     <= S_IDLE;
                        end else if (!r_x[0]) begin
                            r_x     <= r_x + NIDX_W'(1);
                            r_state <= S_RD;
                        end else begin
                            r_x     <= r_x >> 1;
                            r_lvl   <= r_lvl - LVL_W'(1);
                            r_pu2   <= 1'b0;
                            r_state <= S_PU1;
                        end
                    end
                    S_PU1: begin
                        if (r_pu2) begin
                            r_left  <= rdata;
                            r_pu2   <= 1'b0;
                            r_state <= S_PU3;
                        end else begin
                            r_pu2 <= 1'b1;
                        end
                    end
                    S_PU3: begin
                        r_state <= S_RET;
                    end
                    default: begin
                        r_state <= S_CLEAR;
                    end
                endcase
            end
        end
    end

    `RAST_ASSERT_IMP(a_clear_stalls, r_state == S_CLEAR, o_in_stall)
    `RAST_ASSERT(a_lvl_range, r_lvl <= LVL_W'(LVLS))
    `RAST_ASSERT_IMP(a_node_level, r_state == S_EV, (r_x >> r_lvl) == NIDX_W'(1))
    `RAST_ASSERT_IMP(a_busy_no_out, r_state != S_IDLE && r_state != S_CLEAR, !r_out_valid)
endmodule
